// ===== rtl/complex_arithmetic_unit_assert.svh =====
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arithmetic_unit: next-cycle check failed");

`endif

// ===== rtl/cau_pkg.sv =====
package cau_pkg;

    // operand and intermediate widths
    localparam int DATA_W = 16;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int NUM_W  = MAG_W + FRAC_W + 1;
    localparam int QUO_W  = DATA_W + 1;
    localparam int CMP_W  = MAG_W + QUO_W;

    // operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RCP = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // saturation bounds at intermediate width
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } cau_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic [1:0]               status;
    } cau_rsp_t;

    // clamp to data width, msb reports clipping
    function automatic logic [DATA_W:0] sat_fn(input logic signed [SUM_W-1:0] v);
        logic [DATA_W:0] r;
        begin
            if (v > SAT_HI)
            begin
                r = {1'b1, SAT_HI[DATA_W-1:0]};
            end
            else if (v < SAT_LO)
            begin
                r = {1'b1, SAT_LO[DATA_W-1:0]};
            end
            else
            begin
                r = {1'b0, v[DATA_W-1:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide and reciprocal on
// signed Q8.8 complex operands, one transaction accepted per cycle while req_stall is low. Every
// transaction passes from acceptance to result through an input register,
// a multiplier stage (six 16x16 products), a combine stage, a magnitude stage,
// a range-check stage, a 17-stage restoring divider that settles one quotient
// bit per stage for both parts, and the output register. Each stage moves on
// as soon as the next one is free, so bubbles close up while the output waits.
// Saturated results report status 1; a zero divisor gives zero and status 2.
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  cau_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output cau_rsp_t rsp
);

    localparam int DV_N = QUO_W + 2;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p3;
        logic signed [PROD_W-1:0] p4;
        logic signed [PROD_W-1:0] p5;
        logic signed [DATA_W:0]   sre;
        logic signed [DATA_W:0]   sim;
    } s2_t;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [SUM_W-1:0] vre;
        logic signed [SUM_W-1:0] vim;
        logic [MAG_W-1:0]        den;
    } s3_t;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic              clip;
        logic [DATA_W-1:0] dre;
        logic [DATA_W-1:0] dim;
        logic [MAG_W-1:0]  den;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [NUM_W-1:0]  r_re;
        logic [NUM_W-1:0]  r_im;
        logic [QUO_W-1:0]  q_re;
        logic [QUO_W-1:0]  q_im;
    } dv_t;

    cau_req_t s1_reg;
    s2_t      s2_reg, s2_next;
    s3_t      s3_reg, s3_next;
    dv_t      dv_reg  [DV_N];
    dv_t      dv_next [DV_N];
    cau_rsp_t rsp_reg, rsp_next;

    logic            s1_vld_reg, s2_vld_reg, s3_vld_reg, rsp_valid_reg;
    logic [DV_N-1:0] dv_vld_reg;
    logic            adv1, adv2, adv3, adv_out;
    logic [DV_N-1:0] adv_dv;

    // stage advance chain, a stage loads when empty or when its successor moves
    always_comb
    begin
        adv_out = !rsp_valid_reg || !rsp_stall;
        adv_dv[DV_N-1] = !dv_vld_reg[DV_N-1] || adv_out;
        for (int j = DV_N - 2; j >= 0; j--)
        begin
            adv_dv[j] = !dv_vld_reg[j] || adv_dv[j+1];
        end
        adv3 = !s3_vld_reg || adv_dv[0];
        adv2 = !s2_vld_reg || adv3;
        adv1 = !s1_vld_reg || adv2;
    end

    assign req_stall = !adv1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            dv_vld_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_vld_reg <= req_valid;
            end
            if (adv2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (adv_dv[0])
            begin
                dv_vld_reg[0] <= s3_vld_reg;
            end
            for (int j = 1; j < DV_N; j++)
            begin
                if (adv_dv[j])
                begin
                    dv_vld_reg[j] <= dv_vld_reg[j-1];
                end
            end
            if (adv_out)
            begin
                rsp_valid_reg <= dv_vld_reg[DV_N-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_reg <= req;
        end
        if (adv2)
        begin
            s2_reg <= s2_next;
        end
        if (adv3)
        begin
            s3_reg <= s3_next;
        end
        for (int j = 0; j < DV_N; j++)
        begin
            if (adv_dv[j])
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
        if (adv_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // products and component sums
    always_comb
    begin
        logic rcp;
        logic signed [DATA_W-1:0] x4, x5;
        rcp = (s1_reg.action == OP_RCP);
        x4  = rcp ? s1_reg.a_re : s1_reg.b_re;
        x5  = rcp ? s1_reg.a_im : s1_reg.b_im;
        s2_next.op   = s1_reg.action;
        s2_next.a_re = s1_reg.a_re;
        s2_next.a_im = s1_reg.a_im;
        s2_next.p0   = PROD_W'(s1_reg.a_re) * PROD_W'(s1_reg.b_re);
        s2_next.p1   = PROD_W'(s1_reg.a_im) * PROD_W'(s1_reg.b_im);
        s2_next.p2   = PROD_W'(s1_reg.a_re) * PROD_W'(s1_reg.b_im);
        s2_next.p3   = PROD_W'(s1_reg.a_im) * PROD_W'(s1_reg.b_re);
        s2_next.p4   = PROD_W'(x4) * PROD_W'(x4);
        s2_next.p5   = PROD_W'(x5) * PROD_W'(x5);
        if (s1_reg.action == OP_SUB)
        begin
            s2_next.sre = (DATA_W+1)'(s1_reg.a_re) - (DATA_W+1)'(s1_reg.b_re);
            s2_next.sim = (DATA_W+1)'(s1_reg.a_im) - (DATA_W+1)'(s1_reg.b_im);
        end
        else
        begin
            s2_next.sre = (DATA_W+1)'(s1_reg.a_re) + (DATA_W+1)'(s1_reg.b_re);
            s2_next.sim = (DATA_W+1)'(s1_reg.a_im) + (DATA_W+1)'(s1_reg.b_im);
        end
    end

    // combine products into numerators and denominator
    always_comb
    begin
        logic signed [SUM_W-1:0] sh_re, sh_im;
        sh_re = SUM_W'(s2_reg.a_re) <<< FRAC_W;
        sh_im = SUM_W'(s2_reg.a_im) <<< FRAC_W;
        s3_next.op  = s2_reg.op;
        s3_next.den = $unsigned(s2_reg.p4) + $unsigned(s2_reg.p5);
        case (s2_reg.op)
            OP_ADD, OP_SUB:
            begin
                s3_next.vre = SUM_W'(s2_reg.sre);
                s3_next.vim = SUM_W'(s2_reg.sim);
            end
            OP_MUL:
            begin
                s3_next.vre = SUM_W'(s2_reg.p0) - SUM_W'(s2_reg.p1);
                s3_next.vim = SUM_W'(s2_reg.p2) + SUM_W'(s2_reg.p3);
            end
            OP_DIV:
            begin
                s3_next.vre = SUM_W'(s2_reg.p0) + SUM_W'(s2_reg.p1);
                s3_next.vim = SUM_W'(s2_reg.p3) - SUM_W'(s2_reg.p2);
            end
            OP_RCP:
            begin
                s3_next.vre = sh_re;
                s3_next.vim = -sh_im;
            end
            default:
            begin
                s3_next.vre = '0;
                s3_next.vim = '0;
            end
        endcase
    end

    // direct results clamped (multiply results rounded first), quotient magnitudes prepared
    always_comb
    begin
        logic signed [SUM_W-1:0] wre, wim;
        logic [DATA_W:0]         sre, sim;
        logic [MAG_W-1:0]        mre, mim;
        if (s3_reg.op == OP_MUL)
        begin
            wre = (s3_reg.vre + SUM_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
            wim = (s3_reg.vim + SUM_W'(1 << (FRAC_W - 1))) >>> FRAC_W;
        end
        else
        begin
            wre = s3_reg.vre;
            wim = s3_reg.vim;
        end
        sre = sat_fn(wre);
        sim = sat_fn(wim);
        mre = s3_reg.vre[SUM_W-1] ? MAG_W'(-s3_reg.vre) : MAG_W'(s3_reg.vre);
        mim = s3_reg.vim[SUM_W-1] ? MAG_W'(-s3_reg.vim) : MAG_W'(s3_reg.vim);
        dv_next[0].is_div = (s3_reg.op == OP_DIV) || (s3_reg.op == OP_RCP);
        dv_next[0].dz     = (s3_reg.den == '0);
        dv_next[0].clip   = sre[DATA_W] | sim[DATA_W];
        dv_next[0].dre    = sre[DATA_W-1:0];
        dv_next[0].dim    = sim[DATA_W-1:0];
        dv_next[0].den    = s3_reg.den;
        dv_next[0].neg_re = s3_reg.vre[SUM_W-1];
        dv_next[0].neg_im = s3_reg.vim[SUM_W-1];
        dv_next[0].ovf_re = 1'b0;
        dv_next[0].ovf_im = 1'b0;
        dv_next[0].r_re   = NUM_W'({mre, {FRAC_W{1'b0}}}) + NUM_W'(s3_reg.den >> 1);
        dv_next[0].r_im   = NUM_W'({mim, {FRAC_W{1'b0}}}) + NUM_W'(s3_reg.den >> 1);
        dv_next[0].q_re   = '0;
        dv_next[0].q_im   = '0;
    end

    // quotient range check against the widest quotient kept
    always_comb
    begin
        logic [CMP_W-1:0] lim;
        lim = {dv_reg[0].den, {QUO_W{1'b0}}};
        dv_next[1] = dv_reg[0];
        dv_next[1].ovf_re = (CMP_W'(dv_reg[0].r_re) >= lim);
        dv_next[1].ovf_im = (CMP_W'(dv_reg[0].r_im) >= lim);
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar j = 2; j < DV_N; j++)
    begin : g_div
        localparam int K = DV_N - 1 - j;
        always_comb
        begin
            logic [CMP_W-1:0] t;
            t = CMP_W'(dv_reg[j-1].den) << K;
            dv_next[j] = dv_reg[j-1];
            if (CMP_W'(dv_reg[j-1].r_re) >= t)
            begin
                dv_next[j].r_re    = NUM_W'(CMP_W'(dv_reg[j-1].r_re) - t);
                dv_next[j].q_re[K] = 1'b1;
            end
            if (CMP_W'(dv_reg[j-1].r_im) >= t)
            begin
                dv_next[j].r_im    = NUM_W'(CMP_W'(dv_reg[j-1].r_im) - t);
                dv_next[j].q_im[K] = 1'b1;
            end
        end
    end

    // sign, clamp and status
    always_comb
    begin
        dv_t d;
        logic pc_re, pc_im, nc_re, nc_im, cre, cim;
        logic [DATA_W-1:0] vre, vim;
        d = dv_reg[DV_N-1];
        pc_re = d.ovf_re || (d.q_re >= QUO_W'(1 << (DATA_W - 1)));
        pc_im = d.ovf_im || (d.q_im >= QUO_W'(1 << (DATA_W - 1)));
        nc_re = d.ovf_re || (d.q_re > QUO_W'(1 << (DATA_W - 1)));
        nc_im = d.ovf_im || (d.q_im > QUO_W'(1 << (DATA_W - 1)));
        cre = d.neg_re ? nc_re : pc_re;
        cim = d.neg_im ? nc_im : pc_im;
        if (d.neg_re)
        begin
            vre = nc_re ? SAT_LO[DATA_W-1:0] : DATA_W'(QUO_W'(0) - d.q_re);
        end
        else
        begin
            vre = pc_re ? SAT_HI[DATA_W-1:0] : d.q_re[DATA_W-1:0];
        end
        if (d.neg_im)
        begin
            vim = nc_im ? SAT_LO[DATA_W-1:0] : DATA_W'(QUO_W'(0) - d.q_im);
        end
        else
        begin
            vim = pc_im ? SAT_HI[DATA_W-1:0] : d.q_im[DATA_W-1:0];
        end
        if (!d.is_div)
        begin
            rsp_next.res_re = d.dre;
            rsp_next.res_im = d.dim;
            rsp_next.status = d.clip ? ST_SAT : ST_OK;
        end
        else if (d.dz)
        begin
            rsp_next.res_re = '0;
            rsp_next.res_im = '0;
            rsp_next.status = ST_DZ;
        end
        else
        begin
            rsp_next.res_re = vre;
            rsp_next.res_im = vim;
            rsp_next.status = (cre | cim) ? ST_SAT : ST_OK;
        end
    end

    // checks
    `CAU_ASSERT_IMP(a_dz_zero, rsp_valid && rsp.status == ST_DZ, rsp.res_re == '0 && rsp.res_im == '0)
    `CAU_ASSERT_IMP(a_status_code, rsp_valid, rsp.status == ST_OK || rsp.status == ST_SAT || rsp.status == ST_DZ)
    `CAU_ASSERT_IMP(a_stall_full, req_stall, s1_vld_reg && s2_vld_reg && s3_vld_reg)
    `CAU_ASSERT_NXT(a_drain, rsp_valid && !rsp_stall && !dv_vld_reg[DV_N-1], !rsp_valid)

endmodule
